// ----- rtl/plid_pkg.sv -----
`timescale 1ns / 1ps
// Package for the positional list insert/delete unit.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies.
package plid_pkg;

    // Field widths of the item and result beats
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // Default number of list entries
    localparam int DEPTH_DEF = 16;

    // Removed-value codes for items that return no entry
    localparam logic [VAL_W-1:0] REMOVED_ERR  = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] REMOVED_NONE = '0;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // Controller states: result register empty or holding a result
    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_HOLD = 1'b1
    } t_ctrl_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic do_insert;
        logic do_delete;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_insert;
        logic full;
        logic ins_pos_ok;
        logic del_pos_ok;
    } t_dp_stat;

endpackage

// ----- rtl/plid_in_if.sv -----
`timescale 1ns / 1ps
// Item channel of the positional list unit: valid/ready plus item payload.
// Depends on plid_pkg.
interface plid_in_if;
    import plid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output opcode, output position, output value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input value,
                    output ready);
endinterface

// ----- rtl/plid_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the positional list unit: valid/ready plus result payload.
// Depends on plid_pkg.
interface plid_out_if;
    import plid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, output status, output removed_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entry_count, output ready);
endinterface

// ----- rtl/positional_list_insert_delete_unit.sv -----
`timescale 1ns / 1ps
// Top level of the positional list insert/delete unit.
// Depends on plid_pkg, plid_in_if, plid_out_if, plid_ctrl and plid_dp.
//
// Keeps an ordered list of up to DEPTH signed 32-bit entries. An insert beat
// places a value at 1-based position p (1..count+1) and moves the later
// entries up; a delete beat removes and returns the entry at p (1..count) and
// moves the later entries down. Each item beat yields one result beat with a
// status (ok, full, bad position), the removed value (0 for inserts, -1 on a
// failed delete) and the new entry count. On acceptance the whole entry row
// shifts at once from a position compare broadcast to every entry, and the
// result appears in the output register the cycle after acceptance. A new
// item is taken every cycle while results are drained; the output register
// holds a result under back-pressure. No clearing pass is run after reset;
// the list is empty as soon as reset is released.
module positional_list_insert_delete_unit #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plid_in_if.sink     i_in,
    plid_out_if.source  o_out
);
    import plid_pkg::*;

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    plid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    plid_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_in.opcode),
        .i_position      (i_in.position),
        .i_value         (i_in.value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_out.status),
        .o_removed_value (o_out.removed_value),
        .o_entry_count   (o_out.entry_count)
    );

endmodule

// ----- rtl/plid_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the positional list unit: handshakes and datapath commands.
// Depends on plid_pkg.
module plid_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  plid_pkg::t_dp_stat i_stat,
    output plid_pkg::t_cmd     o_cmd
);
    import plid_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        // take a new item when the result register is empty or being drained
        o_in_ready  = (r_state == CS_IDLE) || i_out_ready;
        o_out_valid = (r_state == CS_HOLD);
        w_accept    = i_in_valid && o_in_ready;

        o_cmd.load      = w_accept;
        o_cmd.do_insert = w_accept && i_stat.is_insert && !i_stat.full && i_stat.ins_pos_ok;
        o_cmd.do_delete = w_accept && !i_stat.is_insert && i_stat.del_pos_ok;

        n_state = r_state;
        case (r_state)
            CS_IDLE: begin
                if (w_accept) begin
                    n_state = CS_HOLD;
                end
            end
            CS_HOLD: begin
                if (!w_accept && i_out_ready) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/plid_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the positional list unit: entry row, count, result register.
// Depends on plid_pkg.
module plid_dp #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_opcode,
    input  logic [plid_pkg::POS_W-1:0]        i_position,
    input  logic signed [plid_pkg::VAL_W-1:0] i_value,
    input  plid_pkg::t_cmd                    i_cmd,
    output plid_pkg::t_dp_stat                o_stat,
    output logic [plid_pkg::STAT_W-1:0]       o_status,
    output logic signed [plid_pkg::VAL_W-1:0] o_removed_value,
    output logic [plid_pkg::CNT_W-1:0]        o_entry_count
);
    import plid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0]  r_list [DEPTH];
    logic [VAL_W-1:0]  n_list [DEPTH];
    logic [VAL_W-1:0]  w_prev [DEPTH];
    logic [VAL_W-1:0]  w_next [DEPTH];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [PW-1:0]     w_pos;
    logic [PW-1:0]     w_cnt;
    logic [PW-1:0]     w_idx;
    t_status           w_res_status;
    logic [VAL_W-1:0]  w_res_removed;
    t_status           r_status;
    logic [VAL_W-1:0]  r_removed;
    logic [CNT_W-1:0]  r_cnt_out;

    // Position checks against the current count
    always_comb begin
        w_pos = PW'(i_position);
        w_cnt = PW'(r_count);
        w_idx = w_pos - PW'(1);
        o_stat.is_insert  = (i_opcode == OP_INSERT);
        o_stat.full       = (r_count == CW'(DEPTH));
        o_stat.ins_pos_ok = (i_position != '0) && (w_pos <= w_cnt + PW'(1));
        o_stat.del_pos_ok = (i_position != '0) && (w_pos <= w_cnt);
    end

    // Neighbour taps of each entry; the ends take the new value or hold
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign w_prev[g] = i_value;
        end else begin : g_mid_lo
            assign w_prev[g] = r_list[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = r_list[g];
        end else begin : g_mid_hi
            assign w_next[g] = r_list[g+1];
        end
    end

    // Broadcast compare: entries at or past the position move up or down
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_list[i] = r_list[i];
            if (i_cmd.do_insert) begin
                if (PW'(i) > w_idx) begin
                    n_list[i] = w_prev[i];
                end else if (PW'(i) == w_idx) begin
                    n_list[i] = i_value;
                end
            end else if (i_cmd.do_delete) begin
                if (PW'(i) >= w_idx) begin
                    n_list[i] = w_next[i];
                end
            end
        end
    end

    // New count and result of this beat
    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.do_delete) begin
            n_count = r_count - CW'(1);
        end

        if (o_stat.is_insert) begin
            w_res_removed = REMOVED_NONE;
            if (o_stat.full) begin
                w_res_status = ST_FULL;
            end else if (o_stat.ins_pos_ok) begin
                w_res_status = ST_OK;
            end else begin
                w_res_status = ST_BADPOS;
            end
        end else if (o_stat.del_pos_ok) begin
            w_res_status  = ST_OK;
            w_res_removed = r_list[w_idx[IW-1:0]];
        end else begin
            w_res_status  = ST_BADPOS;
            w_res_removed = REMOVED_ERR;
        end
    end

    // Entry row, no reset: only entries below the count are ever read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_list[i] <= n_list[i];
        end
    end

    // Count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status  <= w_res_status;
            r_removed <= w_res_removed;
            r_cnt_out <= CNT_W'(n_count);
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_cnt_out;

    // The count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A successful insert grows the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    // A successful delete shrinks the count by one
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_delete |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink the count");

    // Insert and delete are never commanded together
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.do_insert && i_cmd.do_delete))
        else $error("insert and delete commanded together");

    // The reported count follows the stored count after a load
    a_count_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_cnt_out == CNT_W'(r_count))
        else $error("reported count differs from stored count");

endmodule
